FILE: src/latency_histogram_recorder_defines.svh
// Assertion macros shared by the checker of latency_histogram_recorder.
// Each macro samples on the rising edge of clk; the first one is switched
// off while rst_n is low, the second one also watches the reset cycles.
`ifndef LATENCY_HISTOGRAM_RECORDER_DEFINES_SVH
`define LATENCY_HISTOGRAM_RECORDER_DEFINES_SVH

// Check a property outside reset
`define LHR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property that also covers the reset cycles
`define LHR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/lhr_pkg.sv
`default_nettype none

package lhr_pkg;

  // Field widths
  localparam int TICK_W    = 64;
  localparam int FREQ_W    = 32;
  localparam int SEL_W     = 5;
  localparam int BKT_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Action codes of an input item
  localparam logic [1:0] ACT_RECORD = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_FREQ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIST_EN   = 1'b1;

  localparam logic [FREQ_W-1:0] FREQ_RESET    = 32'd10000000;
  localparam logic [19:0]       US_PER_SECOND = 20'd1000000;

  // Divider: one quotient bit per cycle
  localparam int DIV_STEPS = 64;
  localparam int STEP_W    = 6;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_IGNORE = 2'd3
  } lhr_kind_t;

  typedef struct packed {
    lhr_kind_t          kind;
    logic [TICK_W-1:0]  product;
    logic [SEL_W-1:0]   sel;
  } lhr_job_t;

endpackage

`default_nettype wire

FILE: src/lhr_queue.sv
`default_nettype none

module lhr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lhr_pkg::lhr_job_t push_job,
  input  logic              pop,
  output lhr_pkg::lhr_job_t pop_job,
  output logic              full,
  output logic              empty
);
  import lhr_pkg::*;

  lhr_job_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     fill_r, fill_nxt;

  assign full    = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (fill_r == '0);
  assign pop_job = slot_r[rd_ptr_r];

  // Track the fill level
  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (QPTR_W+1)'(1);
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  // Hold item payloads
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

FILE: src/lhr_front.sv
`default_nettype none

module lhr_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_action,
  input  logic signed [lhr_pkg::TICK_W-1:0] in_elapsed_ticks,
  input  logic [lhr_pkg::SEL_W-1:0]    in_bucket_select,
  input  logic [lhr_pkg::FREQ_W-1:0]   tick_freq,
  input  logic                         q_full,
  output logic                         push,
  output lhr_pkg::lhr_job_t            push_job
);
  import lhr_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE   = 4'b0001,
    F_MUL_LO = 4'b0010,
    F_MUL_HI = 4'b0100,
    F_PUSH   = 4'b1000
  } front_state_t;

  front_state_t      state_r, state_nxt;
  logic [TICK_W-1:0] ticks_r;
  logic [51:0]       lo_r;
  logic [31:0]       hi_r;
  logic [51:0]       lo_prod;
  logic [31:0]       hi_prod;
  logic [TICK_W-1:0] product;
  lhr_kind_t         kind;
  logic              accept;

  assign busy   = (state_r != F_IDLE) || q_full;
  assign accept = start && !busy;

  // Classify the item
  always_comb begin
    case (in_action)
      ACT_RECORD: begin
        kind = (in_elapsed_ticks[TICK_W-1] || (tick_freq == '0)) ? KIND_IGNORE : KIND_RECORD;
      end
      ACT_READ:  kind = KIND_READ;
      ACT_CLEAR: kind = KIND_CLEAR;
      ACT_NOP:   kind = KIND_IGNORE;
      default:   kind = KIND_IGNORE;
    endcase
  end

  // Scale ticks to microseconds modulo 2^64 in two halves
  assign lo_prod = 52'(ticks_r[31:0]) * 52'(US_PER_SECOND);
  assign hi_prod = ticks_r[63:32] * 32'(US_PER_SECOND);
  assign product = {hi_r, 32'b0} + 64'(lo_r);

  // Hand the item to the queue
  always_comb begin
    push_job = '{kind: kind, product: '0, sel: in_bucket_select};
    push     = accept && (kind != KIND_RECORD);
    if (state_r == F_PUSH) begin
      push_job = '{kind: KIND_RECORD, product: product, sel: '0};
      push     = !q_full;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:   if (accept && (kind == KIND_RECORD)) state_nxt = F_MUL_LO;
      F_MUL_LO: state_nxt = F_MUL_HI;
      F_MUL_HI: state_nxt = F_PUSH;
      F_PUSH:   if (!q_full) state_nxt = F_IDLE;
      default:  state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold operand and partial products
  always_ff @(posedge clk) begin
    if (accept) begin
      ticks_r <= in_elapsed_ticks;
    end
    if (state_r == F_MUL_LO) begin
      lo_r <= lo_prod;
    end
    if (state_r == F_MUL_HI) begin
      hi_r <= hi_prod;
    end
  end

endmodule

`default_nettype wire

FILE: src/lhr_back.sv
`default_nettype none

module lhr_back #(
  parameter int BUCKET_COUNT = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  output logic                        pop,
  input  lhr_pkg::lhr_job_t           job,
  input  logic [lhr_pkg::FREQ_W-1:0]  tick_freq,
  input  logic                        hist_en,
  output logic                        out_valid,
  output logic                        out_recorded,
  output logic [lhr_pkg::TICK_W-1:0]  out_latency_us,
  output logic [lhr_pkg::SEL_W-1:0]   out_bucket_index,
  output logic [lhr_pkg::TICK_W-1:0]  out_bucket_count,
  output logic [lhr_pkg::TICK_W-1:0]  out_running_sum,
  output logic [lhr_pkg::TICK_W-1:0]  out_running_max
);
  import lhr_pkg::*;

  localparam int AW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(BUCKET_COUNT - 1);
  localparam logic [BKT_W-1:0] NUM_BKT  = BKT_W'(BUCKET_COUNT);

  typedef enum logic [4:0] {
    B_IDLE   = 5'b00001,
    B_DIV    = 5'b00010,
    B_LOOKUP = 5'b00100,
    B_FETCH  = 5'b01000,
    B_UPDATE = 5'b10000
  } back_state_t;

  back_state_t        state_r, state_nxt;
  lhr_kind_t          kind_r;
  logic [TICK_W-1:0]  quo_r;
  logic [FREQ_W-1:0]  rem_r;
  logic [STEP_W-1:0]  step_r;
  logic               found_r;
  logic [STEP_W-1:0]  pos_r;
  logic [BKT_W-1:0]   idx_r;
  logic               hit_r;
  logic               vld_rd_r;
  logic [TICK_W-1:0]  rd_data_r;
  logic [TICK_W-1:0]  count_r;
  logic [TICK_W-1:0]  sum_r, max_r;
  logic [BUCKET_COUNT-1:0] valid_r;
  logic [TICK_W-1:0]  mem [BUCKET_COUNT];

  logic               out_valid_r, out_valid_nxt;
  logic               out_recorded_r;
  logic [TICK_W-1:0]  out_latency_r;
  logic [SEL_W-1:0]   out_idx_r;
  logic [TICK_W-1:0]  out_count_r;

  logic               is_rec;
  logic [FREQ_W:0]    rsh, dsub;
  logic               ge;
  logic [BKT_W-1:0]   bkt_raw, bkt_rec, look_idx;
  logic               in_range;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               bump, mem_we, clear_all;
  logic [TICK_W-1:0]  cur_count, new_count;

  assign pop       = (state_r == B_IDLE) && !q_empty;
  assign is_rec    = (kind_r == KIND_RECORD);
  assign clear_all = pop && (job.kind == KIND_CLEAR);

  // One restoring divide step: shift in the next dividend bit, try subtract
  assign rsh  = {rem_r, quo_r[TICK_W-1]};
  assign dsub = rsh - {1'b0, tick_freq};
  assign ge   = (rsh >= {1'b0, tick_freq});

  // Bucket: one above the highest quotient bit, saturated at the last bucket
  assign bkt_raw  = BKT_W'(pos_r) + BKT_W'(1);
  assign bkt_rec  = !found_r ? '0 : ((bkt_raw >= LAST_BKT) ? LAST_BKT : bkt_raw);
  assign look_idx = is_rec ? bkt_rec : idx_r;
  assign in_range = (look_idx < NUM_BKT);
  assign rd_addr  = in_range ? AW'(look_idx) : '0;

  // Count update; an entry never written since clear reads as zero
  assign cur_count = (hit_r && vld_rd_r) ? rd_data_r : '0;
  assign bump      = is_rec && hist_en;
  assign new_count = count_r + TICK_W'(bump);
  assign mem_we    = (state_r == B_UPDATE) && bump;
  assign wr_addr   = AW'(idx_r);

  assign out_valid_nxt = (pop && ((job.kind == KIND_CLEAR) || (job.kind == KIND_IGNORE)))
                         || (state_r == B_UPDATE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (pop) begin
          case (job.kind)
            KIND_RECORD: state_nxt = B_DIV;
            KIND_READ:   state_nxt = B_LOOKUP;
            default:     state_nxt = B_IDLE;
          endcase
        end
      end
      B_DIV:    if (step_r == '0) state_nxt = B_LOOKUP;
      B_LOOKUP: state_nxt = B_FETCH;
      B_FETCH:  state_nxt = B_UPDATE;
      B_UPDATE: state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  // Control state, statistics and bucket valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      max_r       <= '0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (clear_all) begin
        sum_r   <= '0;
        max_r   <= '0;
        valid_r <= '0;
      end else begin
        if ((state_r == B_FETCH) && is_rec) begin
          sum_r <= sum_r + quo_r;
          if (quo_r > max_r) begin
            max_r <= quo_r;
          end
        end
        if (mem_we) begin
          valid_r[wr_addr] <= 1'b1;
        end
      end
    end
  end

  // Datapath and result payload
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (pop) begin
          kind_r         <= job.kind;
          quo_r          <= job.product;
          rem_r          <= '0;
          step_r         <= STEP_W'(DIV_STEPS - 1);
          found_r        <= 1'b0;
          pos_r          <= '0;
          idx_r          <= BKT_W'(job.sel);
          out_recorded_r <= 1'b0;
          out_latency_r  <= '0;
          out_idx_r      <= '0;
          out_count_r    <= '0;
        end
      end
      B_DIV: begin
        rem_r  <= ge ? dsub[FREQ_W-1:0] : rsh[FREQ_W-1:0];
        quo_r  <= {quo_r[TICK_W-2:0], ge};
        step_r <= step_r - STEP_W'(1);
        if (ge && !found_r) begin
          found_r <= 1'b1;
          pos_r   <= step_r;
        end
      end
      B_LOOKUP: begin
        idx_r    <= look_idx;
        hit_r    <= in_range;
        vld_rd_r <= valid_r[rd_addr];
      end
      B_FETCH: begin
        count_r <= cur_count;
      end
      B_UPDATE: begin
        out_recorded_r <= is_rec;
        out_latency_r  <= is_rec ? quo_r : '0;
        out_idx_r      <= idx_r[SEL_W-1:0];
        out_count_r    <= new_count;
      end
      default: begin
      end
    endcase
  end

  // Bucket memory: registered read, one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= new_count;
    end
    if (state_r == B_LOOKUP) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_recorded     = out_recorded_r;
  assign out_latency_us   = out_latency_r;
  assign out_bucket_index = out_idx_r;
  assign out_bucket_count = out_count_r;
  assign out_running_sum  = sum_r;
  assign out_running_max  = max_r;

endmodule

`default_nettype wire

FILE: src/latency_histogram_recorder.sv
// A record item is scaled to microseconds in the front (MUL_LO, MUL_HI, PUSH), waits in the
// queue, is divided by tick_frequency in a radix-2 divider and updates its bucket (LOOKUP,
// FETCH, UPDATE); a read takes those three bucket states, a clear, skipped record or no-op none.
// The bit-serial divider limits how often records complete; a two-entry queue lets up to two
// items be taken while a divide runs. The receiver cannot stall.
// Reset (synchronous, rst_n low): sum, maximum and all bucket counts read zero the next cycle.
`default_nettype none

module latency_histogram_recorder #(
  parameter int BUCKET_COUNT = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_action,
  input  logic signed [lhr_pkg::TICK_W-1:0] in_elapsed_ticks,
  input  logic [lhr_pkg::SEL_W-1:0]         in_bucket_select,
  input  logic                              cfg_wr_en,
  input  logic [lhr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lhr_pkg::FREQ_W-1:0]        cfg_wdata,
  output logic                              out_valid,
  output logic                              out_recorded,
  output logic [lhr_pkg::TICK_W-1:0]        out_latency_us,
  output logic [lhr_pkg::SEL_W-1:0]         out_bucket_index,
  output logic [lhr_pkg::TICK_W-1:0]        out_bucket_count,
  output logic [lhr_pkg::TICK_W-1:0]        out_running_sum,
  output logic [lhr_pkg::TICK_W-1:0]        out_running_max
);
  import lhr_pkg::*;

  logic [FREQ_W-1:0] freq_r;
  logic              hist_en_r;
  logic              push, pop, q_full, q_empty;
  lhr_job_t          push_job, pop_job;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r    <= FREQ_RESET;
      hist_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TICK_FREQ: freq_r    <= cfg_wdata;
        CFG_HIST_EN:   hist_en_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  lhr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_elapsed_ticks (in_elapsed_ticks),
    .in_bucket_select (in_bucket_select),
    .tick_freq        (freq_r),
    .q_full           (q_full),
    .push             (push),
    .push_job         (push_job)
  );

  lhr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  lhr_back #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .pop              (pop),
    .job              (pop_job),
    .tick_freq        (freq_r),
    .hist_en          (hist_en_r),
    .out_valid        (out_valid),
    .out_recorded     (out_recorded),
    .out_latency_us   (out_latency_us),
    .out_bucket_index (out_bucket_index),
    .out_bucket_count (out_bucket_count),
    .out_running_sum  (out_running_sum),
    .out_running_max  (out_running_max)
  );

endmodule

`default_nettype wire

FILE: src/lhr_checker.sv
`default_nettype none
`include "latency_histogram_recorder_defines.svh"

module lhr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic        out_recorded,
  input logic [63:0] out_latency_us,
  input logic [4:0]  out_bucket_index,
  input logic [63:0] out_running_max
);

  // Leave reset idle with no result pending
  `LHR_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid && !busy, "result or busy after reset")

  // A result that counted nothing carries no latency
  `LHR_ASSERT(a_skip_no_latency, out_valid && !out_recorded |-> out_latency_us == 64'd0, "latency on uncounted item")

  // The running maximum covers every counted latency
  `LHR_ASSERT(a_max_covers, out_valid && out_recorded |-> out_running_max >= out_latency_us, "maximum below latency")

  // A zero latency lands in bucket zero
  `LHR_ASSERT(a_zero_bucket, out_valid && out_recorded && out_latency_us == 64'd0 |-> out_bucket_index == 5'd0, "zero latency outside bucket zero")

endmodule

bind latency_histogram_recorder lhr_checker u_lhr_checker (.*);

`default_nettype wire

FILE: bench/latency_histogram_recorder_test.sv
`timescale 1ns / 100ps

module latency_histogram_recorder_test;
  import lhr_pkg::*;

  localparam int NUM_BUCKETS   = 32;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [TICK_W-1:0] TICKS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [TICK_W-1:0] TICKS_MIN = 64'h8000_0000_0000_0000;
  localparam logic [TICK_W-1:0] TICKS_ALL = 64'hFFFF_FFFF_FFFF_FFFF;

  // One statistics snapshot as the block reports it
  typedef struct {
    logic              recorded;
    logic [TICK_W-1:0] latency_us;
    logic [SEL_W-1:0]  bucket_index;
    logic [TICK_W-1:0] bucket_count;
    logic [TICK_W-1:0] running_sum;
    logic [TICK_W-1:0] running_max;
  } stats_t;

  logic                     clk              = 1'b0;
  logic                     rst_n            = 1'b0;
  logic                     start            = 1'b0;
  logic                     busy;
  logic [1:0]               in_action        = ACT_NOP;
  logic signed [TICK_W-1:0] in_elapsed_ticks = '0;
  logic [SEL_W-1:0]         in_bucket_select = '0;
  logic                     cfg_wr_en        = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index        = CFG_TICK_FREQ;
  logic [FREQ_W-1:0]        cfg_wdata        = '0;
  logic                     out_valid;
  logic                     out_recorded;
  logic [TICK_W-1:0]        out_latency_us;
  logic [SEL_W-1:0]         out_bucket_index;
  logic [TICK_W-1:0]        out_bucket_count;
  logic [TICK_W-1:0]        out_running_sum;
  logic [TICK_W-1:0]        out_running_max;

  // Own copy of the recorder's registers and statistics
  logic [FREQ_W-1:0] freq_now;
  logic              hist_on;
  logic [TICK_W-1:0] sum_now;
  logic [TICK_W-1:0] max_now;
  logic [TICK_W-1:0] bucket_tally [NUM_BUCKETS];

  stats_t stats_due[$];
  int     mismatches;
  int     cycle_count;
  int     n_counted, n_skipped, n_reads, n_clears, n_nops, n_settings;

  latency_histogram_recorder #(
    .BUCKET_COUNT(NUM_BUCKETS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_elapsed_ticks (in_elapsed_ticks),
    .in_bucket_select (in_bucket_select),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_recorded     (out_recorded),
    .out_latency_us   (out_latency_us),
    .out_bucket_index (out_bucket_index),
    .out_bucket_count (out_bucket_count),
    .out_running_sum  (out_running_sum),
    .out_running_max  (out_running_max)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bucket of a microsecond value: one plus its top set bit, saturated
  function automatic logic [SEL_W-1:0] log2_bucket_of(logic [TICK_W-1:0] us);
    int top;
    int b;
    top = -1;
    for (int i = 0; i < TICK_W; i++)
      if (us[i]) top = i;
    b = top + 1;
    if (b > NUM_BUCKETS - 1) b = NUM_BUCKETS - 1;
    return b[SEL_W-1:0];
  endfunction

  // Apply one item to the statistics and return the snapshot it yields
  function automatic stats_t update_latency_stats(logic [1:0] act, logic [TICK_W-1:0] ticks,
                                                  logic [SEL_W-1:0] sel);
    stats_t            r;
    logic [TICK_W-1:0] scaled;
    logic [SEL_W-1:0]  b;
    r.recorded     = 1'b0;
    r.latency_us   = '0;
    r.bucket_index = '0;
    r.bucket_count = '0;
    case (act)
      ACT_RECORD: begin
        if (!ticks[TICK_W-1] && freq_now != '0) begin
          scaled = ticks * {44'd0, US_PER_SECOND};
          r.latency_us = scaled / {32'd0, freq_now};
          sum_now = sum_now + r.latency_us;
          if (r.latency_us > max_now) max_now = r.latency_us;
          b = log2_bucket_of(r.latency_us);
          if (hist_on) bucket_tally[b] = bucket_tally[b] + 64'd1;
          r.recorded     = 1'b1;
          r.bucket_index = b;
          r.bucket_count = bucket_tally[b];
          n_counted++;
        end else begin
          n_skipped++;
        end
      end
      ACT_READ: begin
        r.bucket_index = sel;
        r.bucket_count = (sel < NUM_BUCKETS) ? bucket_tally[sel] : '0;
        n_reads++;
      end
      ACT_CLEAR: begin
        sum_now = '0;
        max_now = '0;
        for (int i = 0; i < NUM_BUCKETS; i++) bucket_tally[i] = '0;
        n_clears++;
      end
      default: begin
        n_nops++;
      end
    endcase
    r.running_sum = sum_now;
    r.running_max = max_now;
    return r;
  endfunction

  // Present one item, hold it until taken, then log its expected snapshot
  task automatic send_item(logic [1:0] act, logic [TICK_W-1:0] ticks, logic [SEL_W-1:0] sel);
    start            <= 1'b1;
    in_action        <= act;
    in_elapsed_ticks <= ticks;
    in_bucket_select <= sel;
    do @(posedge clk); while (busy !== 1'b0);
    stats_due.push_back(update_latency_stats(act, ticks, sel));
  endtask

  task automatic idle_gap(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off the sender until every outstanding snapshot has come back
  task automatic drain();
    start <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers back to back while the block is idle
  task automatic set_config(logic [FREQ_W-1:0] freq, logic enable);
    logic [FREQ_W-1:0] noise;
    noise = $urandom;
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_TICK_FREQ;
    cfg_wdata <= freq;
    @(posedge clk);
    cfg_index <= CFG_HIST_EN;
    cfg_wdata <= {noise[FREQ_W-1:1], enable};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    freq_now = freq;
    hist_on  = enable;
    n_settings++;
  endtask

  // Ticks spread over all bucket sizes, with some full-width and negative ones
  function automatic logic [TICK_W-1:0] draw_ticks();
    logic [TICK_W-1:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return raw;
      1:       return raw | TICKS_MIN;
      default: return raw >> $urandom_range(1, 63);
    endcase
  endfunction

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65)
      send_item(ACT_RECORD, draw_ticks(), SEL_W'($urandom_range(0, 31)));
    else if (pick < 90)
      send_item(ACT_READ, {$urandom, $urandom}, SEL_W'($urandom_range(0, 31)));
    else if (pick < 96)
      send_item(ACT_NOP, {$urandom, $urandom}, SEL_W'($urandom_range(0, 31)));
    else
      send_item(ACT_CLEAR, {$urandom, $urandom}, SEL_W'($urandom_range(0, 31)));
  endtask

  // Extremes of the tick count and every action at the reset settings
  task automatic test_directed_items();
    send_item(ACT_RECORD, 64'd0, 5'd0);
    send_item(ACT_RECORD, 64'd1, 5'd31);
    send_item(ACT_RECORD, 64'd10, 5'd0);
    send_item(ACT_RECORD, 64'd123456789, 5'd0);
    send_item(ACT_RECORD, TICKS_MAX, 5'd0);
    send_item(ACT_RECORD, TICKS_MIN, 5'd0);
    send_item(ACT_RECORD, TICKS_ALL, 5'd0);
    send_item(ACT_READ, TICKS_ALL, 5'd0);
    send_item(ACT_READ, 64'd0, 5'd1);
    send_item(ACT_READ, 64'd0, 5'd31);
    send_item(ACT_NOP, TICKS_MAX, 5'd31);
    send_item(ACT_CLEAR, TICKS_ALL, 5'd31);
    send_item(ACT_READ, 64'd0, 5'd0);
  endtask

  // Register extremes: unit and top frequency, zero frequency, histogram off
  task automatic test_register_extremes();
    set_config(32'd1, 1'b1);
    send_item(ACT_RECORD, TICKS_MAX, 5'd0);
    send_item(ACT_RECORD, TICKS_MAX, 5'd0);
    send_item(ACT_RECORD, 64'd1, 5'd0);
    send_item(ACT_READ, 64'd0, 5'd31);
    set_config(32'hFFFF_FFFF, 1'b1);
    send_item(ACT_RECORD, TICKS_MAX, 5'd0);
    send_item(ACT_RECORD, 64'd4294, 5'd0);
    set_config(32'd0, 1'b1);
    send_item(ACT_RECORD, 64'd5, 5'd0);
    send_item(ACT_READ, 64'd0, 5'd0);
    set_config(32'd1000000, 1'b0);
    send_item(ACT_RECORD, 64'd12345, 5'd0);
    send_item(ACT_READ, 64'd0, 5'd14);
    send_item(ACT_CLEAR, 64'd0, 5'd0);
  endtask

  // One random phase under a fixed setting, draining once midway
  task automatic run_phase(logic [FREQ_W-1:0] freq, logic enable, int items, bit gaps);
    int calm;
    calm = 0;
    set_config(freq, enable);
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) drain();
      if (gaps) begin
        if (calm > 0) calm--;
        else if ($urandom_range(0, 39) == 0) calm = $urandom_range(20, 60);
        else if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 14));
      end
      random_item();
    end
  endtask

  task automatic test_random_traffic();
    int per_phase;
    per_phase = RANDOM_ITEMS / 8;
    run_phase(FREQ_RESET, 1'b1, per_phase, 1'b1);
    run_phase(32'd1, 1'b1, per_phase, 1'b1);
    run_phase(32'hFFFF_FFFF, 1'b1, per_phase, 1'b1);
    run_phase(32'd1000000, 1'b0, per_phase, 1'b1);
    run_phase(32'd0, 1'b1, per_phase / 2, 1'b1);
    run_phase($urandom_range(1, 1000), 1'b1, per_phase, 1'b1);
    run_phase($urandom, 1'b1, per_phase, 1'b1);
    run_phase($urandom_range(1, 100000000), 1'b1, per_phase + per_phase / 2, 1'b0);
  endtask

  // Compare every strobed snapshot with the oldest one expected
  always @(posedge clk) begin : check_results
    stats_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (stats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with nothing outstanding (us=%h idx=%0d)",
                   $time, out_latency_us, out_bucket_index);
      end else begin
        want = stats_due.pop_front();
        if (out_recorded !== want.recorded || out_latency_us !== want.latency_us ||
            out_bucket_index !== want.bucket_index ||
            out_bucket_count !== want.bucket_count ||
            out_running_sum !== want.running_sum || out_running_max !== want.running_max)
        begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: want rec=%b us=%h idx=%0d cnt=%h sum=%h max=%h", $time,
                     want.recorded, want.latency_us, want.bucket_index, want.bucket_count,
                     want.running_sum, want.running_max);
            $display("%0t: got  rec=%b us=%h idx=%0d cnt=%h sum=%h max=%h", $time,
                     out_recorded, out_latency_us, out_bucket_index, out_bucket_count,
                     out_running_sum, out_running_max);
          end
        end
      end
    end
  end

  // Stop a hung run
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[latency_histogram_recorder] ERROR");
    $finish;
  end

  initial begin
    freq_now = FREQ_RESET;
    hist_on  = 1'b1;
    sum_now  = '0;
    max_now  = '0;
    for (int i = 0; i < NUM_BUCKETS; i++) bucket_tally[i] = '0;
    mismatches = 0;
    n_counted = 0; n_skipped = 0; n_reads = 0; n_clears = 0; n_nops = 0; n_settings = 0;

    // Hold reset, then release
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_items();
    test_register_extremes();
    test_random_traffic();

    // Let the last snapshots come back
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d counted and %0d skipped records, %0d reads, %0d clears, %0d no-ops",
             n_counted, n_skipped, n_reads, n_clears, n_nops);
    $display("over %0d register settings; %0d mismatches, %0d snapshots outstanding",
             n_settings, mismatches, stats_due.size());
    if (mismatches == 0 && stats_due.size() == 0)
      $display("[latency_histogram_recorder] OK");
    else
      $display("[latency_histogram_recorder] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/lhr_pkg.sv
src/lhr_queue.sv
src/lhr_front.sv
src/lhr_back.sv
src/latency_histogram_recorder.sv
src/lhr_checker.sv
bench/latency_histogram_recorder_test.sv
